### hdl/isnb_pkg.sv
// Shared types and constants of the nearest/bilinear face resampler.
package isnb_pkg;

  localparam int COORD_W    = 12;
  localparam int CH_W       = 8;
  localparam int PIX_W      = 32;
  localparam int WGT_W      = 16;
  localparam int IDX_W      = 10;
  localparam int SIZE_W     = 11;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;
  localparam int QUEUE_DEPTH = 4;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  localparam logic [WGT_W:0] WGT_ONE  = 17'h10000;
  localparam logic [31:0]    HALF_PIX = 32'h0000_8000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SRC_W  = 3'd0,
    REG_SRC_H  = 3'd1,
    REG_DST_W  = 3'd2,
    REG_DST_H  = 3'd3,
    REG_FILTER = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic               op;
    logic [COORD_W-1:0] pos_x;
    logic [COORD_W-1:0] pos_y;
    logic [CH_W-1:0]    in_red;
    logic [CH_W-1:0]    in_green;
    logic [CH_W-1:0]    in_blue;
    logic [CH_W-1:0]    in_alpha;
  } in_item_t;

  typedef struct packed {
    logic [CH_W-1:0] out_red;
    logic [CH_W-1:0] out_green;
    logic [CH_W-1:0] out_blue;
    logic [CH_W-1:0] out_alpha;
  } out_item_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] wdata;
  } cfg_item_t;

  // effective source geometry and filter, handed to the front end
  typedef struct packed {
    logic [SIZE_W-1:0] src_w;
    logic [SIZE_W-1:0] src_h;
    logic              bilinear;
  } geom_t;

  // one request as queued between front and back end
  typedef struct packed {
    logic             sample;
    logic             wr;
    logic [IDX_W-1:0] x1;
    logic [IDX_W-1:0] x2;
    logic [IDX_W-1:0] y1;
    logic [IDX_W-1:0] y2;
    logic [WGT_W-1:0] wx;
    logic [WGT_W-1:0] wy;
    logic [PIX_W-1:0] pix;
  } job_t;

endpackage

### hdl/isnb_if.sv
// Channel interfaces: request input, result output and register write port.
interface isnb_in_if;
  logic               valid;
  logic               ready;
  isnb_pkg::in_item_t item;
  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

interface isnb_out_if;
  logic                valid;
  logic                ready;
  isnb_pkg::out_item_t item;
  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

interface isnb_cfg_if;
  logic                valid;
  logic                ready;
  isnb_pkg::cfg_item_t item;
  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

### hdl/image_scaler_nearest_bilinear_core.sv
// Top level of the nearest/bilinear cube face resampler.
// Channels: in_ch takes requests (op 0 loads one RGBA pixel into the face
// store at pos_x/pos_y, op 1 samples the destination pixel at pos_x/pos_y);
// out_ch returns one RGBA pixel per sample request and nothing for a load;
// cfg_ch writes the five registers (source size, destination size, filter).
// Throughput: one request per cycle while the steps are not being recomputed
// and the queue is not full; results come back in request order.
// After reset, and after every register write, the two step values are
// recomputed by bit-serial dividers, during which in_ch.ready is low.
// Register writes are always taken and belong to idle periods.
// Registers reset to 64, 64, 64, 64 and bilinear.
// A stalled receiver holds the output register; the back end stops with it,
// and the four-entry queue plus the front pipeline absorb requests in flight
// before in_ch.ready drops. The face store is not cleared at reset.
module image_scaler_nearest_bilinear_core #(
  parameter int MAX_SOURCE_SIDE = 64,
  parameter int FRACTION_BITS   = 48
) (
  input  logic        clk,
  input  logic        rst_n,
  isnb_in_if.sink     in_ch,
  isnb_out_if.source  out_ch,
  isnb_cfg_if.sink    cfg_ch
);

  localparam int SZW   = $clog2(MAX_SOURCE_SIDE + 1);
  localparam int NUM_W = SZW + FRACTION_BITS;
  localparam int DW    = isnb_pkg::CFG_DATA_W;

  logic [6:0]      src_w_r, src_h_r;
  logic [DW-1:0]   dst_w_r, dst_h_r;
  logic            filt_r;
  logic            start_r;
  logic            cfg_acc;
  logic            busy, busy_x, busy_y;
  logic [SZW-1:0]  sw, sh;
  logic [DW-1:0]   dw, dh;
  logic [NUM_W-1:0] quo_x, quo_y;
  isnb_pkg::geom_t geom;
  logic            full, empty, push, pop;
  isnb_pkg::job_t  push_data, pop_data;

  function automatic logic [SZW-1:0] src_size(input logic [6:0] v);
    if (v == '0) begin
      return SZW'(1);
    end else if (32'(v) > MAX_SOURCE_SIDE) begin
      return SZW'(MAX_SOURCE_SIDE);
    end
    return SZW'(v);
  endfunction

  assign cfg_ch.ready = 1'b1;
  assign cfg_acc      = cfg_ch.valid && cfg_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_w_r <= 7'd64;
      src_h_r <= 7'd64;
      dst_w_r <= 13'd64;
      dst_h_r <= 13'd64;
      filt_r  <= 1'b1;
      start_r <= 1'b1;
    end else begin
      start_r <= cfg_acc;
      if (cfg_acc) begin
        unique case (isnb_pkg::cfg_reg_t'(cfg_ch.item.index))
          isnb_pkg::REG_SRC_W:  src_w_r <= cfg_ch.item.wdata[6:0];
          isnb_pkg::REG_SRC_H:  src_h_r <= cfg_ch.item.wdata[6:0];
          isnb_pkg::REG_DST_W:  dst_w_r <= cfg_ch.item.wdata;
          isnb_pkg::REG_DST_H:  dst_h_r <= cfg_ch.item.wdata;
          isnb_pkg::REG_FILTER: filt_r  <= cfg_ch.item.wdata[0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    sw = src_size(src_w_r);
    sh = src_size(src_h_r);
    dw = (dst_w_r == '0) ? DW'(1) : dst_w_r;
    dh = (dst_h_r == '0) ? DW'(1) : dst_h_r;
    geom.src_w    = isnb_pkg::SIZE_W'(sw);
    geom.src_h    = isnb_pkg::SIZE_W'(sh);
    geom.bilinear = filt_r;
  end

  assign busy = start_r || busy_x || busy_y;

  isnb_div #(.NUM_W(NUM_W)) u_div_x (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start_r),
    .num   ({sw, {FRACTION_BITS{1'b0}}}),
    .den   (dw),
    .busy  (busy_x),
    .quo   (quo_x)
  );

  isnb_div #(.NUM_W(NUM_W)) u_div_y (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start_r),
    .num   ({sh, {FRACTION_BITS{1'b0}}}),
    .den   (dh),
    .busy  (busy_y),
    .quo   (quo_y)
  );

  isnb_front #(
    .MAX_SOURCE_SIDE (MAX_SOURCE_SIDE),
    .FRACTION_BITS   (FRACTION_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .busy      (busy),
    .geom      (geom),
    .step_x    (64'(quo_x)),
    .step_y    (64'(quo_y)),
    .full      (full),
    .push      (push),
    .push_data (push_data)
  );

  isnb_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .full      (full),
    .empty     (empty),
    .pop_data  (pop_data)
  );

  isnb_back #(
    .MAX_SOURCE_SIDE (MAX_SOURCE_SIDE)
  ) u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .empty  (empty),
    .job    (pop_data),
    .pop    (pop),
    .out_ch (out_ch)
  );

`ifndef SYNTHESIS
  a_busy_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !in_ch.ready)
    else $error("request taken while steps are recomputed");

  a_write_restarts_steps: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_acc |=> busy)
    else $error("register write did not restart step computation");

  a_reset_starts_steps: assert property (@(posedge clk)
    !rst_n |=> busy)
    else $error("step computation not started after reset");
`endif

endmodule

### hdl/isnb_div.sv
// Restoring divider, one quotient bit per cycle, for the step values.
module isnb_div #(
  parameter int NUM_W = 55
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic [NUM_W-1:0]                   num,
  input  logic [isnb_pkg::CFG_DATA_W-1:0]    den,
  output logic                               busy,
  output logic [NUM_W-1:0]                   quo
);

  localparam int CNT_W = $clog2(NUM_W + 1);
  localparam int DW    = isnb_pkg::CFG_DATA_W;

  logic             busy_r;
  logic [CNT_W-1:0] cnt_r;
  logic [NUM_W-1:0] quo_r;
  logic [DW-1:0]    rem_r;
  logic [DW:0]      rem_sh;
  logic             ge;
  logic [DW-1:0]    rem_nxt;

  always_comb begin
    rem_sh  = {rem_r, quo_r[NUM_W-1]};
    ge      = rem_sh >= {1'b0, den};
    rem_nxt = ge ? DW'(rem_sh - {1'b0, den}) : DW'(rem_sh);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_W'(NUM_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  // shift the dividend out at the top while quotient bits enter at the bottom
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= num;
      rem_r <= '0;
    end else if (busy_r) begin
      quo_r <= {quo_r[NUM_W-2:0], ge};
      rem_r <= rem_nxt;
    end
  end

  assign busy = busy_r;
  assign quo  = quo_r;

endmodule

### hdl/isnb_front.sv
// Front end: accept requests, form source positions, classify into queue jobs.
module isnb_front #(
  parameter int MAX_SOURCE_SIDE = 64,
  parameter int FRACTION_BITS   = 48
) (
  input  logic                 clk,
  input  logic                 rst_n,
  isnb_in_if.sink              in_ch,
  input  logic                 busy,
  input  isnb_pkg::geom_t      geom,
  input  logic [63:0]          step_x,
  input  logic [63:0]          step_y,
  input  logic                 full,
  output logic                 push,
  output isnb_pkg::job_t       push_data
);

  localparam int IDX_W   = isnb_pkg::IDX_W;
  localparam int SIZE_W  = isnb_pkg::SIZE_W;
  localparam int WHOLE_W = 64 - FRACTION_BITS;

  typedef struct packed {
    logic [IDX_W-1:0]           lo;
    logic [IDX_W-1:0]           hi;
    logic [isnb_pkg::WGT_W-1:0] w;
  } axis_t;

  logic               v1_r, v2_r, v3_r;
  logic               f_en;
  isnb_pkg::in_item_t it1_r, it2_r, it3_r;
  logic [43:0]        lo_x_r, hi_x_r, lo_y_r, hi_y_r;
  logic [63:0]        pos_x_r, pos_y_r;
  logic [63:0]        base_x_r, base_y_r;
  axis_t              ax, ay;
  logic               in_map;

  function automatic axis_t map_axis(input logic [63:0] pos, input logic [SIZE_W-1:0] size,
                                     input logic bil);
    logic [SIZE_W-1:0]  last;
    logic [WHOLE_W-1:0] whole;
    logic [31:0]        t;
    logic [31:0]        tx;
    logic [15:0]        ti;
    axis_t              r;
    last  = size - 1'b1;
    whole = pos[63:FRACTION_BITS];
    t     = pos[FRACTION_BITS-16 +: 32];
    tx    = (t > isnb_pkg::HALF_PIX) ? t - isnb_pkg::HALF_PIX : '0;
    ti    = tx[31:16];
    if (!bil) begin
      r.lo = (whole > WHOLE_W'(last)) ? IDX_W'(last) : IDX_W'(whole);
      r.hi = r.lo;
      r.w  = '0;
    end else begin
      r.lo = (ti > 16'(last)) ? IDX_W'(last) : IDX_W'(ti);
      r.hi = (r.lo == IDX_W'(last)) ? r.lo : r.lo + 1'b1;
      r.w  = tx[15:0];
    end
    return r;
  endfunction

  assign f_en        = !v3_r || !full;
  assign in_ch.ready = f_en && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (f_en) begin
      v1_r <= in_ch.valid && in_ch.ready;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    base_x_r <= (step_x >> 1) - 64'd1;
    base_y_r <= (step_y >> 1) - 64'd1;
    if (f_en) begin
      it1_r   <= in_ch.item;
      it2_r   <= it1_r;
      it3_r   <= it2_r;
      lo_x_r  <= 44'(it1_r.pos_x) * 44'(step_x[31:0]);
      hi_x_r  <= 44'(it1_r.pos_x) * 44'(step_x[63:32]);
      lo_y_r  <= 44'(it1_r.pos_y) * 44'(step_y[31:0]);
      hi_y_r  <= 44'(it1_r.pos_y) * 44'(step_y[63:32]);
      pos_x_r <= base_x_r + {20'b0, lo_x_r} + {hi_x_r[31:0], 32'b0};
      pos_y_r <= base_y_r + {20'b0, lo_y_r} + {hi_y_r[31:0], 32'b0};
    end
  end

  always_comb begin
    ax     = map_axis(pos_x_r, geom.src_w, geom.bilinear);
    ay     = map_axis(pos_y_r, geom.src_h, geom.bilinear);
    in_map = (32'(it3_r.pos_x) < MAX_SOURCE_SIDE) && (32'(it3_r.pos_y) < MAX_SOURCE_SIDE);
    push_data.sample = it3_r.op == isnb_pkg::OP_SAMPLE;
    push_data.wr     = (it3_r.op == isnb_pkg::OP_LOAD) && in_map;
    push_data.pix    = {it3_r.in_alpha, it3_r.in_blue, it3_r.in_green, it3_r.in_red};
    if (it3_r.op == isnb_pkg::OP_SAMPLE) begin
      push_data.x1 = ax.lo;
      push_data.x2 = ax.hi;
      push_data.y1 = ay.lo;
      push_data.y2 = ay.hi;
      push_data.wx = ax.w;
      push_data.wy = ay.w;
    end else begin
      push_data.x1 = IDX_W'(it3_r.pos_x);
      push_data.x2 = IDX_W'(it3_r.pos_x);
      push_data.y1 = IDX_W'(it3_r.pos_y);
      push_data.y2 = IDX_W'(it3_r.pos_y);
      push_data.wx = '0;
      push_data.wy = '0;
    end
  end

  assign push = v3_r && !full;

endmodule

### hdl/isnb_fifo.sv
// Short job queue between front and back end.
module isnb_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  isnb_pkg::job_t push_data,
  input  logic           pop,
  output logic           full,
  output logic           empty,
  output isnb_pkg::job_t pop_data
);

  localparam int DEPTH = isnb_pkg::QUEUE_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  isnb_pkg::job_t   q_r [DEPTH];
  logic [PTR_W-1:0] wp_r, rp_r;
  logic [CNT_W-1:0] cnt_r;

  assign full     = cnt_r == CNT_W'(DEPTH);
  assign empty    = cnt_r == '0;
  assign pop_data = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= rp_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= push_data;
    end
  end

endmodule

### hdl/isnb_back.sv
// Back end: banked face store, weight products, blend and output register.
module isnb_back #(
  parameter int MAX_SOURCE_SIDE = 64
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           empty,
  input  isnb_pkg::job_t job,
  output logic           pop,
  isnb_out_if.source     out_ch
);

  localparam int HALF = (MAX_SOURCE_SIDE + 1) / 2;
  localparam int BD   = HALF * HALF;
  localparam int BAW  = (BD > 1) ? $clog2(BD) : 1;
  localparam int CW   = $clog2(MAX_SOURCE_SIDE);
  localparam int WW   = isnb_pkg::WGT_W + 17;

  logic            b_en;
  logic [BAW-1:0]  raddr [4];
  logic [BAW-1:0]  waddr;
  logic [1:0]      wbank;
  logic [31:0]     rd_r [4];
  logic            b1_v_r, b2_v_r, b3_v_r;
  logic            sx1_r, sx2_r, sy1_r, sy2_r;
  logic [15:0]     wx_r, wy_r;
  logic [16:0]     ix, iy;
  logic [31:0]     p_r [4];
  logic [WW-1:0]   w_r [4];
  logic [40:0]     acc_r [4];
  logic            out_vld_r;
  isnb_pkg::out_item_t out_r;
  logic [7:0]      chan [4];

  function automatic logic [BAW-1:0] bank_addr(input logic [CW-1:0] x, input logic [CW-1:0] y);
    return BAW'(((32'(y) >> 1) * HALF) + (32'(x) >> 1));
  endfunction

  function automatic logic [31:0] pick(input logic sy, input logic sx, input logic [31:0] a,
                                       input logic [31:0] b, input logic [31:0] c,
                                       input logic [31:0] d);
    return sy ? (sx ? d : c) : (sx ? b : a);
  endfunction

  function automatic logic [7:0] round8(input logic [40:0] acc);
    logic [41:0] s;
    s = {1'b0, acc} + 42'h0_8000_0000;
    return (s[41:32] > 10'd255) ? 8'hff : s[39:32];
  endfunction

  assign b_en = !out_vld_r || out_ch.ready;
  assign pop  = b_en && !empty;

  always_comb begin
    for (int b = 0; b < 4; b++) begin
      raddr[b] = bank_addr((job.x1[0] == b[0]) ? job.x1[CW-1:0] : job.x2[CW-1:0],
                           (job.y1[0] == b[1]) ? job.y1[CW-1:0] : job.y2[CW-1:0]);
    end
    waddr = bank_addr(job.x1[CW-1:0], job.y1[CW-1:0]);
    wbank = {job.y1[0], job.x1[0]};
  end

  // four banks split by row and column parity give all four neighbours at once
  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [31:0] mem [BD];
    always_ff @(posedge clk) begin
      if (pop && job.wr && (wbank == 2'(b))) begin
        mem[waddr] <= job.pix;
      end
      if (b_en) begin
        rd_r[b] <= mem[raddr[b]];
      end
    end
  end

  always_comb begin
    ix = isnb_pkg::WGT_ONE - {1'b0, wx_r};
    iy = isnb_pkg::WGT_ONE - {1'b0, wy_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_v_r    <= 1'b0;
      b2_v_r    <= 1'b0;
      b3_v_r    <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (b_en) begin
      b1_v_r    <= pop && job.sample;
      b2_v_r    <= b1_v_r;
      b3_v_r    <= b2_v_r;
      out_vld_r <= b3_v_r;
    end
  end

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      chan[c] = round8(acc_r[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (b_en) begin
      sx1_r <= job.x1[0];
      sx2_r <= job.x2[0];
      sy1_r <= job.y1[0];
      sy2_r <= job.y2[0];
      wx_r  <= job.wx;
      wy_r  <= job.wy;
      p_r[0] <= pick(sy1_r, sx1_r, rd_r[0], rd_r[1], rd_r[2], rd_r[3]);
      p_r[1] <= pick(sy1_r, sx2_r, rd_r[0], rd_r[1], rd_r[2], rd_r[3]);
      p_r[2] <= pick(sy2_r, sx1_r, rd_r[0], rd_r[1], rd_r[2], rd_r[3]);
      p_r[3] <= pick(sy2_r, sx2_r, rd_r[0], rd_r[1], rd_r[2], rd_r[3]);
      w_r[0] <= WW'(34'(ix) * 34'(iy));
      w_r[1] <= WW'(34'({1'b0, wx_r}) * 34'(iy));
      w_r[2] <= WW'(34'(ix) * 34'({1'b0, wy_r}));
      w_r[3] <= WW'(34'({1'b0, wx_r}) * 34'({1'b0, wy_r}));
      for (int c = 0; c < 4; c++) begin
        acc_r[c] <= 41'(43'(p_r[0][8*c +: 8]) * 43'(w_r[0]) +
                        43'(p_r[1][8*c +: 8]) * 43'(w_r[1]) +
                        43'(p_r[2][8*c +: 8]) * 43'(w_r[2]) +
                        43'(p_r[3][8*c +: 8]) * 43'(w_r[3]));
      end
      if (b3_v_r) begin
        out_r.out_red   <= chan[0];
        out_r.out_green <= chan[1];
        out_r.out_blue  <= chan[2];
        out_r.out_alpha <= chan[3];
      end
    end
  end

  assign out_ch.valid = out_vld_r;
  assign out_ch.item  = out_r;

endmodule

### dv/tb.sv
// Self-checking testbench for the nearest/bilinear cube face resampler.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SIDE     = 64;
  localparam int FRAC     = 48;
  localparam int DRAIN_CY = 24;

  logic clk;
  logic rst_n;

  isnb_in_if  in_ch ();
  isnb_out_if out_ch ();
  isnb_cfg_if cfg_ch ();

  image_scaler_nearest_bilinear_core #(
    .MAX_SOURCE_SIDE(SIDE),
    .FRACTION_BITS(FRAC)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch.sink),
    .out_ch(out_ch.source),
    .cfg_ch(cfg_ch.sink)
  );

  // register copies and derived steps
  logic [6:0]  src_w_reg, src_h_reg;
  logic [12:0] dst_w_reg, dst_h_reg;
  logic        bilinear_reg;
  logic [63:0] step_h, step_v;
  logic [31:0] face [SIDE*SIDE];
  bit          loaded [SIDE*SIDE];

  isnb_pkg::out_item_t pending_pixels[$];
  int        mismatches;
  int        sender_idle_pct;
  int        recv_stall_pct;

  typedef struct {
    isnb_pkg::in_item_t  req;
    bit                  typed;
    isnb_pkg::out_item_t pix;
  } row_t;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("tb NOT OK");
    $finish;
  end

  function automatic logic [63:0] eff_src(input logic [6:0] v);
    if (v == 0) return 64'd1;
    if (v > SIDE) return 64'(SIDE);
    return 64'(v);
  endfunction

  function automatic logic [63:0] eff_dst(input logic [12:0] v);
    return (v == 0) ? 64'd1 : 64'(v);
  endfunction

  function automatic void recompute_steps();
    step_h = (eff_src(src_w_reg) << FRAC) / eff_dst(dst_w_reg);
    step_v = (eff_src(src_h_reg) << FRAC) / eff_dst(dst_h_reg);
  endfunction

  function automatic logic [63:0] clampi(input logic [63:0] i, input logic [63:0] n);
    return (i > n - 64'd1) ? n - 64'd1 : i;
  endfunction

  function automatic logic [31:0] half_off(input logic [63:0] p);
    logic [31:0] t;
    t = p[63:32];
    return (t > isnb_pkg::HALF_PIX) ? t - isnb_pkg::HALF_PIX : 32'd0;
  endfunction

  // Work out the resampled pixel; return 0 and the first missing entry when a
  // neighbour has never been loaded.
  function automatic bit resample(input logic [11:0] dx, input logic [11:0] dy,
                                  output isnb_pkg::out_item_t pix, output int missing);
    logic [63:0] px, py, sw, sh, x1, x2, y1, y2, wx, wy, ix, iy, acc, v;
    logic [31:0] tx, ty, p11, p21, p12, p22;
    int          idx [4];
    logic [7:0]  ch [4];
    sw = eff_src(src_w_reg);
    sh = eff_src(src_h_reg);
    px = (step_h >> 1) - 64'd1 + 64'(dx) * step_h;
    py = (step_v >> 1) - 64'd1 + 64'(dy) * step_v;
    if (!bilinear_reg) begin
      x1 = clampi(px >> FRAC, sw);
      y1 = clampi(py >> FRAC, sh);
      x2 = x1; y2 = y1; wx = 64'd0; wy = 64'd0;
    end else begin
      tx = half_off(px);
      ty = half_off(py);
      x1 = clampi(64'(tx >> 16), sw);
      y1 = clampi(64'(ty >> 16), sh);
      x2 = clampi(x1 + 64'd1, sw);
      y2 = clampi(y1 + 64'd1, sh);
      wx = 64'(tx[15:0]);
      wy = 64'(ty[15:0]);
    end
    idx[0] = int'(y1) * SIDE + int'(x1);
    idx[1] = int'(y1) * SIDE + int'(x2);
    idx[2] = int'(y2) * SIDE + int'(x1);
    idx[3] = int'(y2) * SIDE + int'(x2);
    missing = -1;
    for (int k = 0; k < 4; k++)
      if (!loaded[idx[k]] && missing < 0) missing = idx[k];
    pix = '0;
    if (missing >= 0) return 1'b0;
    p11 = face[idx[0]]; p21 = face[idx[1]]; p12 = face[idx[2]]; p22 = face[idx[3]];
    ix = 64'd65536 - wx;
    iy = 64'd65536 - wy;
    for (int c = 0; c < 4; c++) begin
      acc = 64'(p11[8*c +: 8]) * ix * iy + 64'(p21[8*c +: 8]) * wx * iy
          + 64'(p12[8*c +: 8]) * ix * wy + 64'(p22[8*c +: 8]) * wx * wy;
      v = (acc + 64'h8000_0000) >> 32;
      ch[c] = (v > 64'd255) ? 8'hff : v[7:0];
    end
    pix.out_red = ch[0]; pix.out_green = ch[1]; pix.out_blue = ch[2]; pix.out_alpha = ch[3];
    return 1'b1;
  endfunction

  function automatic isnb_pkg::in_item_t mk_req(input logic op, input int x, input int y,
                                                input logic [31:0] rgba);
    isnb_pkg::in_item_t r;
    r.op = op; r.pos_x = x[11:0]; r.pos_y = y[11:0];
    r.in_red = rgba[31:24]; r.in_green = rgba[23:16];
    r.in_blue = rgba[15:8]; r.in_alpha = rgba[7:0];
    return r;
  endfunction

  task automatic report(input string what, input logic [7:0] got, input logic [7:0] want);
    $display("mismatch %s: got %02h want %02h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // Send one request; loads update the store copy, samples queue a pixel.
  task automatic send(input isnb_pkg::in_item_t r, input bit typed,
                      input isnb_pkg::out_item_t typed_pix);
    isnb_pkg::out_item_t p;
    int                  miss;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    if (r.op == isnb_pkg::OP_LOAD) begin
      if (r.pos_x < SIDE && r.pos_y < SIDE) begin
        face[r.pos_y * SIDE + r.pos_x] = {r.in_alpha, r.in_blue, r.in_green, r.in_red};
        loaded[r.pos_y * SIDE + r.pos_x] = 1'b1;
      end
    end else begin
      void'(resample(r.pos_x, r.pos_y, p, miss));
      pending_pixels.push_back(typed ? typed_pix : p);
    end
    in_ch.valid <= 1'b1;
    in_ch.item  <= r;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CY) @(posedge clk);
  endtask

  // Leaves cfg_ch.valid high; the caller drops it after the last write.
  task automatic write_reg(input isnb_pkg::cfg_reg_t idx, input int val);
    isnb_pkg::cfg_item_t c;
    c.index = idx;
    c.wdata = val[isnb_pkg::CFG_DATA_W-1:0];
    cfg_ch.valid <= 1'b1;
    cfg_ch.item  <= c;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      isnb_pkg::REG_SRC_W:  src_w_reg = c.wdata[6:0];
      isnb_pkg::REG_SRC_H:  src_h_reg = c.wdata[6:0];
      isnb_pkg::REG_DST_W:  dst_w_reg = c.wdata[12:0];
      isnb_pkg::REG_DST_H:  dst_h_reg = c.wdata[12:0];
      isnb_pkg::REG_FILTER: bilinear_reg = c.wdata[0];
      default: ;
    endcase
    recompute_steps();
  endtask

  task automatic configure(input int sw, input int sh, input int dw, input int dh,
                           input int mode);
    drain();
    write_reg(isnb_pkg::REG_SRC_W, sw);
    write_reg(isnb_pkg::REG_SRC_H, sh);
    write_reg(isnb_pkg::REG_DST_W, dw);
    write_reg(isnb_pkg::REG_DST_H, dh);
    write_reg(isnb_pkg::REG_FILTER, mode);
    cfg_ch.valid <= 1'b0;
  endtask

  // Mostly in-range samples and loads; unreadable samples become loads of the gap.
  task automatic random_run(input int count, input bit pause_mid);
    isnb_pkg::in_item_t  r;
    isnb_pkg::out_item_t p;
    int                  miss, lim_x, lim_y, sw, sh;
    sw = int'(eff_src(src_w_reg));
    sh = int'(eff_src(src_h_reg));
    lim_x = int'(eff_dst(dst_w_reg)) + 2;
    lim_y = int'(eff_dst(dst_h_reg)) + 2;
    if (lim_x > 4095) lim_x = 4095;
    if (lim_y > 4095) lim_y = 4095;
    for (int n = 0; n < count; n++) begin
      if (pause_mid && n == count / 2) drain();
      r = mk_req(isnb_pkg::OP_LOAD, 0, 0, $urandom);
      case ($urandom_range(9))
        0: begin
          r.pos_x = 12'($urandom);
          r.pos_y = 12'($urandom);
        end
        1, 2: begin
          r.pos_x = 12'($urandom_range(sw - 1));
          r.pos_y = 12'($urandom_range(sh - 1));
        end
        3: begin
          r.op = isnb_pkg::OP_SAMPLE;
          r.pos_x = 12'($urandom);
          r.pos_y = 12'($urandom);
        end
        default: begin
          r.op = isnb_pkg::OP_SAMPLE;
          r.pos_x = 12'($urandom_range(lim_x));
          r.pos_y = 12'($urandom_range(lim_y));
        end
      endcase
      if (r.op == isnb_pkg::OP_SAMPLE && !resample(r.pos_x, r.pos_y, p, miss)) begin
        r.op = isnb_pkg::OP_LOAD;
        r.pos_x = 12'(miss % SIDE);
        r.pos_y = 12'(miss / SIDE);
      end
      send(r, 1'b0, '0);
    end
  endtask

  // result checker
  always @(posedge clk) begin
    isnb_pkg::out_item_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_pixels.size() == 0) begin
        report("unexpected pixel, red", out_ch.item.out_red, 8'h00);
      end else begin
        want = pending_pixels.pop_front();
        if (out_ch.item.out_red !== want.out_red)
          report("red", out_ch.item.out_red, want.out_red);
        if (out_ch.item.out_green !== want.out_green)
          report("green", out_ch.item.out_green, want.out_green);
        if (out_ch.item.out_blue !== want.out_blue)
          report("blue", out_ch.item.out_blue, want.out_blue);
        if (out_ch.item.out_alpha !== want.out_alpha)
          report("alpha", out_ch.item.out_alpha, want.out_alpha);
      end
    end
  end

  // receiver stalls
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  initial begin
    row_t                rows[$];
    row_t                rw;
    isnb_pkg::out_item_t z;
    z = '0;
    mismatches = 0;
    sender_idle_pct = 0;
    recv_stall_pct = 0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.item = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.item = '0;
    out_ch.ready = 1'b1;
    src_w_reg = 7'd64; src_h_reg = 7'd64;
    dst_w_reg = 13'd64; dst_h_reg = 13'd64;
    bilinear_reg = 1'b1;
    recompute_steps();
    foreach (loaded[i]) loaded[i] = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // corners, extremes of every field, loads outside the store
    rows.push_back('{mk_req(isnb_pkg::OP_LOAD, 0, 0, 32'h0000_0000), 0, z});
    rows.push_back('{mk_req(isnb_pkg::OP_LOAD, 1, 0, 32'hffff_ffff), 0, z});
    rows.push_back('{mk_req(isnb_pkg::OP_LOAD, 0, 1, 32'h1234_5678), 0, z});
    rows.push_back('{mk_req(isnb_pkg::OP_LOAD, 1, 1, 32'ha55a_0ff0), 0, z});
    rows.push_back('{mk_req(isnb_pkg::OP_LOAD, 62, 62, 32'h80ff_0001), 0, z});
    rows.push_back('{mk_req(isnb_pkg::OP_LOAD, 63, 62, 32'h7f00_fffe), 0, z});
    rows.push_back('{mk_req(isnb_pkg::OP_LOAD, 62, 63, 32'h0102_0304), 0, z});
    rows.push_back('{mk_req(isnb_pkg::OP_LOAD, 63, 63, 32'hc0de_beef), 0, z});
    rows.push_back('{mk_req(isnb_pkg::OP_LOAD, 0, 63, 32'hfe01_fe01), 0, z});
    rows.push_back('{mk_req(isnb_pkg::OP_LOAD, 1, 63, 32'h00ff_00ff), 0, z});
    rows.push_back('{mk_req(isnb_pkg::OP_LOAD, 64, 0, 32'hdead_dead), 0, z});
    rows.push_back('{mk_req(isnb_pkg::OP_LOAD, 4095, 4095, 32'hffff_ffff), 0, z});
    rows.push_back('{mk_req(isnb_pkg::OP_SAMPLE, 0, 0, 32'hffff_ffff), 1, z});
    rows.push_back('{mk_req(isnb_pkg::OP_SAMPLE, 4095, 4095, 32'h0), 1,
                     isnb_pkg::out_item_t'({8'hc0, 8'hde, 8'hbe, 8'hef})});
    rows.push_back('{mk_req(isnb_pkg::OP_SAMPLE, 1, 0, 32'h0), 0, z});
    rows.push_back('{mk_req(isnb_pkg::OP_SAMPLE, 0, 1, 32'h0), 0, z});
    rows.push_back('{mk_req(isnb_pkg::OP_SAMPLE, 63, 63, 32'h0), 0, z});
    rows.push_back('{mk_req(isnb_pkg::OP_SAMPLE, 0, 4095, 32'h0), 0, z});
    rows.push_back('{mk_req(isnb_pkg::OP_SAMPLE, 64, 64, 32'h0), 0, z});
    foreach (rows[i]) begin
      rw = rows[i];
      send(rw.req, rw.typed, rw.pix);
    end

    random_run(200, 1'b1);
    sender_idle_pct = 86;
    configure(0, 127, 1, 0, 0);
    random_run(150, 1'b0);
    sender_idle_pct = 0;
    recv_stall_pct = 86;
    configure(17, 5, 4096, 8191, 1);
    random_run(250, 1'b0);
    sender_idle_pct = 9;
    recv_stall_pct = 9;
    configure(64, 64, 8191, 1, 0);
    random_run(300, 1'b0);
    sender_idle_pct = 0;
    recv_stall_pct = 0;
    configure(1, 64, 4095, 3, 1);
    random_run(300, 1'b0);
    sender_idle_pct = 86;
    configure(33, 64, 100, 200, 0);
    random_run(200, 1'b0);
    recv_stall_pct = 86;
    sender_idle_pct = 0;
    configure(64, 40, 7, 4096, 1);
    random_run(400, 1'b0);
    drain();

    if (mismatches == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

### sim.f
hdl/isnb_pkg.sv
hdl/isnb_if.sv
hdl/isnb_div.sv
hdl/isnb_front.sv
hdl/isnb_fifo.sv
hdl/isnb_back.sv
hdl/image_scaler_nearest_bilinear_core.sv
dv/tb.sv
